// ===== rtl/oiec_pkg.sv =====
// shared widths, register indexes, reset values and helpers of the image endian converter
package oiec_pkg;

	localparam int unsigned WORD_W    = 16;
	localparam int unsigned IN_USER_W = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned LIT_W     = 6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_METHOD_CLASS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOAT_CLASS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_CLASS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_ARRAY_CLASS = 2'd3;

	localparam logic [WORD_W-1:0] METHOD_CLASS_RST     = 16'd34;
	localparam logic [WORD_W-1:0] FLOAT_CLASS_RST      = 16'd20;
	localparam logic [WORD_W-1:0] BITMAP_CLASS_RST     = 16'd30;
	localparam logic [WORD_W-1:0] WORD_ARRAY_CLASS_RST = 16'd2674;

	// positions inside an object
	localparam logic [WORD_W-1:0] POS_CLASS     = 16'd1;
	localparam logic [WORD_W-1:0] POS_HEADER    = 16'd2;
	localparam logic [WORD_W-1:0] POS_FLOAT_LO  = 16'd3;
	localparam logic [WORD_W-1:0] FLOAT_MIN_LEN = 16'd4;
	localparam logic [WORD_W-1:0] POS_MAX       = 16'hffff;

	// bit places in the input tuser
	localparam int unsigned UB_START = 0;
	localparam int unsigned UB_PTRS  = 1;
	localparam int unsigned UB_FREE  = 2;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
		logic              bad;
	} res_t;

	function automatic logic [WORD_W-1:0] swap16(input logic [WORD_W-1:0] w);
		swap16 = {w[7:0], w[15:8]};
	endfunction

endpackage

// ===== rtl/object_image_endian_converter.sv =====
// object image byte-order converter: input register, convert logic, result queue
// path: a taken word is held in the input register and converted there; its results enter
//   the result queue once the queue has room for two, and leave it from the queue head
// throughput: one word per cycle; a float pair gives two results after a step with none,
//   and the slave side only waits while more than two words sit in the four-deep queue
// reset: arst_n clears object state, the held float word and the queue at once,
//   and loads the class registers with their defaults
module object_image_endian_converter
	import oiec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// slave side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [WORD_W-1:0]    s_tdata,   // [15:0] word_in
	input  logic [IN_USER_W-1:0] s_tuser,   // [0] object_start, [1] holds_pointers, [2] free_entry
	// master side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [WORD_W-1:0]    m_tdata,   // [15:0] word_out
	output logic                 m_tlast,   // last_of_run
	output logic [0:0]           m_tuser,   // [0] bad_method_header
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_CLASS   = 3'd1,
		MODE_METHOD  = 3'd2,
		MODE_FLOAT   = 3'd3,
		MODE_SWAPALL = 3'd4,
		MODE_BYTES   = 3'd5
	} mode_t;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// class registers
	logic [WORD_W-1:0] method_id_q, float_id_q, bitmap_id_q, warray_id_q;

	// input register
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              start_s1, ptrs_s1, free_s1;

	// object state
	logic [WORD_W-1:0] pos_q, len_q;
	mode_t             mode_q;
	logic [LIT_W-1:0]  lit_q;
	logic [WORD_W-1:0] held_q;
	logic              held_valid_q;
	logic              ptr_flag_q;

	// result queue
	res_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// convert logic
	logic              advance, pop;
	logic [WORD_W-1:0] swapped, pos_inc;
	logic              partner, emit_held, hold;
	logic [1:0]        main_n, res_n;
	logic [WORD_W-1:0] main0_word, main1_word;
	logic              main0_bad;
	res_t              ent0, ent1;
	mode_t             nxt_mode;
	logic [WORD_W-1:0] nxt_pos, nxt_len;
	logic [LIT_W-1:0]  nxt_lit;
	logic              nxt_ptr;

	// the slave side only waits when the queue cannot take a two-word run
	assign advance   = valid_s1 && (count_q <= QCNT_W'(QDEPTH - 2));
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = queue_q[rd_ptr_q].word;
	assign m_tlast  = queue_q[rd_ptr_q].last;
	assign m_tuser  = queue_q[rd_ptr_q].bad;
	assign pop      = m_tvalid && m_tready;

	always_comb begin
		swapped    = swap16(word_s1);
		pos_inc    = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;
		// second float body word that completes a held pair
		partner    = !start_s1 && !free_s1 && (mode_q == MODE_FLOAT) &&
		             (pos_q == POS_FLOAT_LO) && (pos_q < len_q);
		emit_held  = held_valid_q && !partner;
		hold       = 1'b0;
		main_n     = 2'd1;
		main0_word = word_s1;
		main0_bad  = 1'b0;
		main1_word = swap16(held_q);
		nxt_mode   = mode_q;
		nxt_pos    = pos_q;
		nxt_len    = len_q;
		nxt_lit    = lit_q;
		nxt_ptr    = ptr_flag_q;

		if (free_s1) begin
			// free words end any object and pass untouched
			nxt_mode = MODE_IDLE;
		end else if (start_s1) begin
			nxt_len    = swapped;
			nxt_ptr    = ptrs_s1;
			nxt_mode   = MODE_CLASS;
			nxt_pos    = POS_CLASS;
			nxt_lit    = '0;
			main0_word = swapped;
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					// loose word, pass
				end
				MODE_CLASS: begin
					main0_word = swapped;
					nxt_pos    = pos_inc;
					if (swapped == method_id_q) begin
						nxt_mode = MODE_METHOD;
					end else if (swapped == float_id_q) begin
						nxt_mode = MODE_FLOAT;
					end else if (ptr_flag_q || swapped == bitmap_id_q ||
					             swapped == warray_id_q) begin
						nxt_mode = MODE_SWAPALL;
					end else begin
						nxt_mode = MODE_BYTES;
					end
				end
				default: begin
					nxt_pos = pos_inc;
					// body words past the object's length pass untouched
					if (pos_q < len_q) begin
						case (mode_q)
							MODE_METHOD: begin
								if (pos_q == POS_HEADER) begin
									nxt_lit    = swapped[LIT_W:1];
									main0_word = swapped;
									main0_bad  = !swapped[0];
								end else if (lit_q != '0) begin
									nxt_lit    = lit_q - LIT_W'(1);
									main0_word = swapped;
								end
							end
							MODE_FLOAT: begin
								if (pos_q == POS_HEADER && len_q >= FLOAT_MIN_LEN) begin
									hold   = 1'b1;
									main_n = 2'd0;
								end else if (partner && held_valid_q) begin
									main0_word = swapped;
									main_n     = 2'd2;
								end
							end
							MODE_SWAPALL: begin
								main0_word = swapped;
							end
							default: begin
								// byte objects pass
							end
						endcase
					end
				end
			endcase
		end

		// a flushed held word always goes out ahead of this word's own result
		res_n = main_n + {1'b0, emit_held};
		if (emit_held) begin
			ent0 = '{word: swap16(held_q), last: 1'b0, bad: 1'b0};
			ent1 = '{word: main0_word, last: 1'b1, bad: main0_bad};
		end else begin
			ent0 = '{word: main0_word, last: 1'b0, bad: main0_bad};
			ent1 = '{word: main1_word, last: 1'b1, bad: 1'b0};
		end
		ent0.last = (res_n == 2'd1);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1  <= s_tdata;
			start_s1 <= s_tuser[UB_START];
			ptrs_s1  <= s_tuser[UB_PTRS];
			free_s1  <= s_tuser[UB_FREE];
		end
	end

	// class registers; the two-bit index covers exactly the four registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_id_q <= METHOD_CLASS_RST;
			float_id_q  <= FLOAT_CLASS_RST;
			bitmap_id_q <= BITMAP_CLASS_RST;
			warray_id_q <= WORD_ARRAY_CLASS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_METHOD_CLASS:     method_id_q <= cfg_data;
				REG_FLOAT_CLASS:      float_id_q  <= cfg_data;
				REG_BITMAP_CLASS:     bitmap_id_q <= cfg_data;
				REG_WORD_ARRAY_CLASS: warray_id_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// object state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			len_q        <= '0;
			mode_q       <= MODE_IDLE;
			lit_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			ptr_flag_q   <= 1'b0;
		end else if (advance) begin
			pos_q        <= nxt_pos;
			len_q        <= nxt_len;
			mode_q       <= nxt_mode;
			lit_q        <= nxt_lit;
			ptr_flag_q   <= nxt_ptr;
			// any held word is either flushed or paired on this step
			held_valid_q <= hold;
			if (hold) begin
				held_q <= word_s1;
			end
		end
	end

	// result queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(res_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (advance ? QCNT_W'(res_n) : '0) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (res_n != 2'd0) begin
				queue_q[wr_ptr_q] <= ent0;
			end
			if (res_n == 2'd2) begin
				queue_q[wr_ptr_q + QPTR_W'(1)] <= ent1;
			end
		end
	end

endmodule

// ===== rtl/oiec_checker.sv =====
// port-level checks of the image endian converter, bound to the top level
module oiec_checker
	import oiec_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [WORD_W-1:0] m_tdata,
	input logic              m_tlast,
	input logic [0:0]        m_tuser
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result word changed under stall");

	// a bad header flag only ever sits on the final word of a run
	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("bad header flag on a non-final word");

	// both words of a run are queued together, so the second follows at once
	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a two-word run");

	// an empty result side never holds back the slave side
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with nothing pending on the output");

endmodule

bind object_image_endian_converter oiec_checker u_oiec_checker (.*);

// ===== tb/sv/tb.sv =====
// self-checking testbench of the object image endian converter
module tb
	import oiec_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// idle cycles with no word moving on any channel before the run is abandoned
	localparam int unsigned IDLE_LIMIT = 2000;
	// cycles left for the block to empty its pipe and result queue
	localparam int unsigned SETTLE_CYCLES = 8;
	// random words per configuration phase
	localparam int unsigned PHASE_WORDS = 100;

	// body treatment chosen from the class word
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_CLASS,
		MODE_METHOD,
		MODE_FLOAT,
		MODE_SWAPALL,
		MODE_BYTES
	} conv_mode_t;

	// shapes of object the random part builds
	typedef enum int unsigned {
		OBJ_METHOD,
		OBJ_FLOAT,
		OBJ_BITMAP,
		OBJ_WORD_ARRAY,
		OBJ_POINTERS,
		OBJ_BYTES
	} obj_kind_t;

	// shadow of the converter: predicts the output words and checks them in order
	class image_swap_board_t;
		logic [WORD_W-1:0] method_id, float_id, bitmap_id, warray_id;
		logic [WORD_W-1:0] pos, obj_len, held;
		logic [LIT_W-1:0]  lits_left;
		conv_mode_t        mode;
		bit                held_v, ptr_flag;
		res_t              owed_q[$];
		int unsigned       errors;

		function new();
			method_id = METHOD_CLASS_RST;
			float_id  = FLOAT_CLASS_RST;
			bitmap_id = BITMAP_CLASS_RST;
			warray_id = WORD_ARRAY_CLASS_RST;
			pos       = '0;
			obj_len   = '0;
			held      = '0;
			lits_left = '0;
			mode      = MODE_IDLE;
			held_v    = 1'b0;
			ptr_flag  = 1'b0;
			errors    = 0;
		endfunction

		function logic [WORD_W-1:0] flip(input logic [WORD_W-1:0] w);
			return {w[7:0], w[15:8]};
		endfunction

		function void owe(input logic [WORD_W-1:0] w, input bit bad);
			res_t r;
			r.word = w;
			r.last = 1'b0;
			r.bad  = bad;
			owed_q.push_back(r);
		endfunction

		function void advance();
			if (pos != POS_MAX)
				pos++;
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
			case (idx)
			REG_METHOD_CLASS:     method_id = v;
			REG_FLOAT_CLASS:      float_id  = v;
			REG_BITMAP_CLASS:     bitmap_id = v;
			REG_WORD_ARRAY_CLASS: warray_id = v;
			default: ;
			endcase
		endfunction

		// one accepted input word: works out the words it releases
		function void note_word(input logic [WORD_W-1:0] w, input bit start, input bit ptrs,
				input bit freew);
			bit                partner;
			logic [WORD_W-1:0] c, h;
			int unsigned       n0;
			n0 = owed_q.size();
			// second float body word following its held partner
			partner = !start && !freew && mode == MODE_FLOAT && pos == POS_FLOAT_LO &&
				pos < obj_len;

			// a held float word whose partner did not come goes out first
			if (held_v && !partner) begin
				owe(flip(held), 1'b0);
				held_v = 1'b0;
			end

			if (freew) begin
				mode = MODE_IDLE;
				owe(w, 1'b0);
			end else if (start) begin
				obj_len   = flip(w);
				ptr_flag  = ptrs;
				mode      = MODE_CLASS;
				pos       = POS_CLASS;
				lits_left = '0;
				owe(flip(w), 1'b0);
			end else if (mode == MODE_IDLE) begin
				owe(w, 1'b0);
			end else if (mode == MODE_CLASS) begin
				c = flip(w);
				if (c == method_id)
					mode = MODE_METHOD;
				else if (c == float_id)
					mode = MODE_FLOAT;
				else if (ptr_flag || c == bitmap_id || c == warray_id)
					mode = MODE_SWAPALL;
				else
					mode = MODE_BYTES;
				owe(c, 1'b0);
				advance();
			end else begin
				if (pos >= obj_len) begin
					owe(w, 1'b0);
				end else if (mode == MODE_METHOD) begin
					if (pos == POS_HEADER) begin
						h = flip(w);
						lits_left = h[6:1];
						owe(h, !h[0]);
					end else if (lits_left != '0) begin
						lits_left--;
						owe(flip(w), 1'b0);
					end else begin
						owe(w, 1'b0);
					end
				end else if (mode == MODE_FLOAT) begin
					if (pos == POS_HEADER && obj_len >= FLOAT_MIN_LEN) begin
						held   = w;
						held_v = 1'b1;
					end else if (partner && held_v) begin
						owe(flip(w), 1'b0);
						owe(flip(held), 1'b0);
						held_v = 1'b0;
					end else begin
						owe(w, 1'b0);
					end
				end else if (mode == MODE_SWAPALL) begin
					owe(flip(w), 1'b0);
				end else begin
					owe(w, 1'b0);
				end
				advance();
			end

			if (owed_q.size() > n0)
				owed_q[owed_q.size() - 1].last = 1'b1;
		endfunction

		task report(input string msg);
			errors++;
			$display("%0t ns: %s", $time, msg);
		endtask

		// one accepted output word against the oldest one owed
		task check_result(input logic [WORD_W-1:0] w, input logic last, input logic bad);
			res_t e;
			if (owed_q.size() == 0) begin
				report($sformatf("word %h arrived with none owed", w));
			end else begin
				e = owed_q.pop_front();
				if (w !== e.word)
					report($sformatf("word_out %h, owed %h", w, e.word));
				if (last !== e.last)
					report($sformatf("last_of_run %b, owed %b (word %h)", last, e.last, e.word));
				if (bad !== e.bad)
					report($sformatf("bad_method_header %b, owed %b (word %h)", bad, e.bad,
						e.word));
			end
		endtask
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [WORD_W-1:0]    s_tdata   = '0;
	logic [IN_USER_W-1:0] s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [WORD_W-1:0]    m_tdata;
	logic                 m_tlast;
	logic [0:0]           m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0]    cfg_data  = '0;

	image_swap_board_t board;

	// class ids the stimulus builds objects from, kept in step with the block
	logic [WORD_W-1:0] cls_now [4] = '{METHOD_CLASS_RST, FLOAT_CLASS_RST, BITMAP_CLASS_RST,
		WORD_ARRAY_CLASS_RST};

	int unsigned words_sent = 0;
	int unsigned burst_left = 0;
	bit          steady     = 1'b0;   // no gaps on the slave side while set
	int unsigned idle_count = 0;

	logic [15:0] ready_pat  = 16'hffff;
	logic [6:0]  ready_tick = '0;

	object_image_endian_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: a rotating ready pattern, reloaded whenever the seven-bit tick wraps,
	// now and then all ones for a stretch with no stalls
	always @(posedge clk) begin
		if (ready_tick == '0) begin
			if ($urandom_range(0, 3) == 0)
				ready_pat <= 16'hffff;
			else
				ready_pat <= 16'($urandom) | 16'h0001;
		end else begin
			ready_pat <= {ready_pat[0], ready_pat[15:1]};
		end
		ready_tick <= ready_tick + 7'd1;
		m_tready   <= ready_pat[0];
	end

	// monitor: every handshake is sampled at the edge that completes it
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				board.check_result(m_tdata, m_tlast, m_tuser[0]);
			if (s_tvalid && s_tready)
				board.note_word(s_tdata, s_tuser[UB_START], s_tuser[UB_PTRS], s_tuser[UB_FREE]);
			if (cfg_valid && cfg_ready)
				board.set_reg(cfg_index, cfg_data);
		end
	end

	// watchdog: too long with nothing moving means the block has hung
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_count = 0;
		end else begin
			idle_count++;
			if (idle_count >= IDLE_LIMIT) begin
				$display("object_image_endian_converter: mismatch");
				$finish;
			end
		end
	end

	// class ids travel high byte first in the image
	function automatic logic [WORD_W-1:0] as_stored(input logic [WORD_W-1:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	// one word on the slave side, in bursts with random gaps between them
	task automatic send_word(input logic [WORD_W-1:0] w, input bit start, input bit ptrs,
			input bit freew);
		logic [IN_USER_W-1:0] u;
		int unsigned          gap;
		u = '0;
		u[UB_START] = start;
		u[UB_PTRS]  = ptrs;
		u[UB_FREE]  = freew;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= u;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	// wait for every owed word, then give the pipe time to empty
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cls_now[idx] = v;
	endtask

	// all four class ids back to back, valid held high across them
	task automatic load_classes(input logic [WORD_W-1:0] m, input logic [WORD_W-1:0] f,
			input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] a);
		put_reg(REG_METHOD_CLASS, m);
		put_reg(REG_FLOAT_CLASS, f);
		put_reg(REG_BITMAP_CLASS, b);
		put_reg(REG_WORD_ARRAY_CLASS, a);
		cfg_valid <= 1'b0;
	endtask

	// loose words, free words and stray starts between objects
	task automatic noise_words();
		int unsigned n;
		n = $urandom_range(1, 3);
		repeat (n)
			send_word(16'($urandom), $urandom_range(0, 3) == 0, 1'($urandom), 1'($urandom));
	endtask

	// one well-formed object with random content, sometimes cut short
	task automatic random_object();
		obj_kind_t         kind;
		logic [WORD_W-1:0] len, cls;
		bit                ptrs;
		int unsigned       body;
		kind = obj_kind_t'($urandom_range(0, 5));
		ptrs = 1'b0;
		case (kind)
		OBJ_METHOD:     cls = cls_now[REG_METHOD_CLASS];
		OBJ_FLOAT:      cls = cls_now[REG_FLOAT_CLASS];
		OBJ_BITMAP:     cls = cls_now[REG_BITMAP_CLASS];
		OBJ_WORD_ARRAY: cls = cls_now[REG_WORD_ARRAY_CLASS];
		OBJ_POINTERS: begin
			cls  = 16'($urandom);
			ptrs = 1'b1;
		end
		default:        cls = 16'($urandom);
		endcase
		// mostly short objects, now and then a random full-width size that the body seldom reaches
		if ($urandom_range(0, 15) == 0) begin
			len  = 16'($urandom);
			body = $urandom_range(0, 20);
		end else begin
			len  = 16'($urandom_range(0, 10));
			body = $urandom_range(1, int'(len) + 2);
		end

		send_word(as_stored(len), 1'b1, ptrs, 1'b0);
		if (body > 0)
			send_word(as_stored(cls), 1'b0, 1'($urandom), 1'b0);
		for (int unsigned i = 1; i < body; i++) begin
			// a free word ends the object early
			if ($urandom_range(0, 29) == 0) begin
				send_word(16'($urandom), 1'($urandom), 1'($urandom), 1'b1);
				break;
			end
			send_word(16'($urandom), 1'b0, 1'($urandom), 1'b0);
		end
	endtask

	initial begin
		int unsigned target;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// loose words at both extremes
		send_word(16'hffff, 1'b0, 1'b0, 1'b0);
		send_word(16'h0000, 1'b0, 1'b0, 1'b0);
		// free entry wins over a start mark
		send_word(16'h1234, 1'b1, 1'b1, 1'b1);
		// method: size 6, header with two literals and its marker bit clear,
		// one plain word, one word beyond the size
		send_word(16'h0600, 1'b1, 1'b0, 1'b0);
		send_word(as_stored(METHOD_CLASS_RST), 1'b0, 1'b0, 1'b0);
		send_word(16'h0400, 1'b0, 1'b0, 1'b0);
		send_word(16'ha55a, 1'b0, 1'b0, 1'b0);
		send_word(16'h00ff, 1'b0, 1'b0, 1'b0);
		send_word(16'h1234, 1'b0, 1'b0, 1'b0);
		send_word(16'hbeef, 1'b0, 1'b0, 1'b0);
		// float: first body word held, both come out swapped in reverse order
		send_word(16'h0400, 1'b1, 1'b0, 1'b0);
		send_word(as_stored(FLOAT_CLASS_RST), 1'b0, 1'b0, 1'b0);
		send_word(16'h3f80, 1'b0, 1'b0, 1'b0);
		send_word(16'h0001, 1'b0, 1'b0, 1'b0);
		// broken float pair, then a float too short to reorder
		send_word(16'h0400, 1'b1, 1'b0, 1'b0);
		send_word(as_stored(FLOAT_CLASS_RST), 1'b0, 1'b0, 1'b0);
		send_word(16'hc0de, 1'b0, 1'b0, 1'b0);
		send_word(16'h0300, 1'b1, 1'b0, 1'b0);
		send_word(as_stored(FLOAT_CLASS_RST), 1'b0, 1'b0, 1'b0);
		send_word(16'h7777, 1'b0, 1'b0, 1'b0);
		// pointer object of an unknown class, followed by a free word and a loose word
		send_word(16'h0300, 1'b1, 1'b1, 1'b0);
		send_word(16'h9999, 1'b0, 1'b0, 1'b0);
		send_word(16'h1200, 1'b0, 1'b0, 1'b0);
		send_word(16'h5678, 1'b0, 1'b0, 1'b1);
		send_word(16'h4321, 1'b0, 1'b0, 1'b0);

		// phase 0 runs on the reset ids, the others on extremes, random ids
		// and finally the defaults again
		for (int unsigned ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				settle();
				case (ph)
				1: load_classes(16'h0000, 16'hffff, 16'h0000, 16'hffff);
				2: load_classes(16'hffff, 16'h0000, 16'hffff, 16'h0000);
				3: load_classes(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				default: load_classes(METHOD_CLASS_RST, FLOAT_CLASS_RST, BITMAP_CLASS_RST,
					WORD_ARRAY_CLASS_RST);
				endcase
			end
			steady = (ph == 2);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				if ($urandom_range(0, 4) == 0)
					noise_words();
				else
					random_object();
			end
		end
		send_word(16'h0200, 1'b0, 1'b0, 1'b0);
		settle();

		if (board.errors == 0)
			$display("object_image_endian_converter: match");
		else
			$display("object_image_endian_converter: mismatch");
		$finish;
	end

endmodule

// ===== object_image_endian_converter.f =====
rtl/oiec_pkg.sv
rtl/object_image_endian_converter.sv
rtl/oiec_checker.sv
tb/sv/tb.sv
